// ----- hw/rtl/rdft_pkg.sv -----
// ---------------------------------------------------------------------------
// rdft_pkg
// Shared types, constants and the square root digit step of the radial fade.
// ---------------------------------------------------------------------------
package rdft_pkg;

  localparam int MAP_COLUMNS_DEF = 30;
  localparam int MAP_ROWS_DEF    = 20;

  localparam int COL_W   = 5;
  localparam int ROW_W   = 5;
  localparam int STEP_W  = 7;
  localparam int IDX_W   = 10;
  localparam int ENTRY_W = 16;
  localparam int POS_W   = 10;   // signed center coordinates
  localparam int TILE_W  = 10;
  localparam int PAL_W   = 4;
  localparam int LEVEL_W = 4;

  localparam int CELL_SHIFT  = 3;    // eight pixels per cell
  localparam int FADE_OFFSET = 64;
  localparam int FADE_RATE   = 5;
  localparam int LEVEL_MAX   = 15;
  localparam int DONE_STEP   = 70;

  localparam int DIST_W = 10;   // absolute pixel distance, at most 760
  localparam int SQ_W   = 2 * DIST_W;
  localparam int RAD_W  = 22;   // radicand, padded to whole bit pairs
  localparam int PAIRS  = RAD_W / 2;
  localparam int ROOT_W = PAIRS;
  localparam int REM_W  = 13;

  localparam logic [1:0] REG_CENTER_X    = 2'd0;
  localparam logic [1:0] REG_CENTER_Y    = 2'd1;
  localparam logic [1:0] REG_TILE_BASE   = 2'd2;
  localparam logic [1:0] REG_PALETTE_SEL = 2'd3;

  localparam logic signed [POS_W-1:0] CENTER_X_RST = 10'sd120;
  localparam logic signed [POS_W-1:0] CENTER_Y_RST = 10'sd80;

  typedef struct packed {
    logic [RAD_W-1:0]  n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [STEP_W-1:0] step;
  } side_t;

  // one restoring digit step: bring down a bit pair, try root*4+1
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] pr);
    logic [REM_W+1:0] r;
    logic [REM_W+1:0] t;
    sqrt_t o;
    o = s;
    r = {s.rem, pr};
    t = {{(REM_W-ROOT_W){1'b0}}, s.root, 2'b01};
    if (r >= t) begin
      o.rem  = REM_W'(r - t);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(r);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- hw/rtl/radial_distance_fade_tile.sv -----
// ---------------------------------------------------------------------------
// radial_distance_fade_tile
// Tilemap entry generator for a circular fade: distance, root, level, entry.
// ---------------------------------------------------------------------------
// One beat in, one beat out, one beat per cycle sustained while out_tready
// stays high. A beat passes seven register stages: distance, square, sum,
// three stages of the eleven-digit square root, and the level/entry register.
// Every stage holds its own valid bit, so a stall on the output fills the
// bubbles ahead of it before in_tready drops. Configuration is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// pipeline is empty, as the block itself does not enforce this.
module radial_distance_fade_tile #(
  parameter int MAP_COLUMNS = rdft_pkg::MAP_COLUMNS_DEF,
  parameter int MAP_ROWS    = rdft_pkg::MAP_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tile_col [4:0], tile_row [9:5], frame_step [16:10], zero pad
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // map_index [9:0], tile_entry [25:10], frame_done [26], zero pad
  output logic [31:0] out_tdata
);

  localparam int COL_W  = rdft_pkg::COL_W;
  localparam int ROW_W  = rdft_pkg::ROW_W;
  localparam int STEP_W = rdft_pkg::STEP_W;
  localparam int POS_W  = rdft_pkg::POS_W;
  localparam int DIST_W = rdft_pkg::DIST_W;
  localparam int SQ_W   = rdft_pkg::SQ_W;
  localparam int RAD_W  = rdft_pkg::RAD_W;
  localparam int SUM_W  = 12;

  // configuration
  logic signed [POS_W-1:0]           center_x_r, center_y_r;
  logic [rdft_pkg::TILE_W-1:0]       tile_base_r;
  logic [rdft_pkg::PAL_W-1:0]        palette_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= rdft_pkg::CENTER_X_RST;
      center_y_r    <= rdft_pkg::CENTER_Y_RST;
      tile_base_r   <= '0;
      palette_sel_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdft_pkg::REG_CENTER_X:    center_x_r    <= $signed(cfg_data);
        rdft_pkg::REG_CENTER_Y:    center_y_r    <= $signed(cfg_data);
        rdft_pkg::REG_TILE_BASE:   tile_base_r   <= cfg_data;
        rdft_pkg::REG_PALETTE_SEL: palette_sel_r <= cfg_data[rdft_pkg::PAL_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain
  logic s1_rdy, s2_rdy, s3_rdy, o_rdy;
  logic q4_rdy, q5_rdy, q6_rdy;
  logic q4_v, q5_v, q6_v;
  rdft_pkg::sqrt_t q4_sq, q5_sq, q6_sq;
  rdft_pkg::side_t q4_side, q5_side, q6_side;

  // stage 1: saturate cell, absolute distances
  logic [COL_W-1:0]          col_sat;
  logic [ROW_W-1:0]          row_sat;
  logic signed [POS_W:0]     dx, dy;
  logic [DIST_W-1:0]         s1_dx_nxt, s1_dy_nxt;
  logic                      s1_v_r;
  logic [DIST_W-1:0]         s1_dx_r, s1_dy_r;
  rdft_pkg::side_t           s1_side_r;

  always_comb begin
    col_sat = in_tdata[COL_W-1:0];
    row_sat = in_tdata[COL_W +: ROW_W];
    if ({1'b0, col_sat} >= (COL_W+1)'(MAP_COLUMNS)) col_sat = COL_W'(MAP_COLUMNS - 1);
    if ({1'b0, row_sat} >= (ROW_W+1)'(MAP_ROWS))    row_sat = ROW_W'(MAP_ROWS - 1);
    dx = {center_x_r[POS_W-1], center_x_r}
       - $signed({3'b000, col_sat, rdft_pkg::CELL_SHIFT'(0)});
    dy = {center_y_r[POS_W-1], center_y_r}
       - $signed({3'b000, row_sat, rdft_pkg::CELL_SHIFT'(0)});
    s1_dx_nxt = dx[POS_W] ? DIST_W'(-dx) : DIST_W'(dx);
    s1_dy_nxt = dy[POS_W] ? DIST_W'(-dy) : DIST_W'(dy);
  end

  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_tvalid;
    end
    if (s1_rdy && in_tvalid) begin
      s1_dx_r        <= s1_dx_nxt;
      s1_dy_r        <= s1_dy_nxt;
      s1_side_r.idx  <= {row_sat, col_sat};
      s1_side_r.step <= in_tdata[COL_W+ROW_W +: STEP_W];
    end
  end

  // stage 2: squares
  logic            s2_v_r;
  logic [SQ_W-1:0] s2_sqx_r, s2_sqy_r;
  rdft_pkg::side_t s2_side_r;

  assign s2_rdy = !s2_v_r || s3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_rdy && s1_v_r) begin
      s2_sqx_r  <= SQ_W'(s1_dx_r) * SQ_W'(s1_dx_r);
      s2_sqy_r  <= SQ_W'(s1_dy_r) * SQ_W'(s1_dy_r);
      s2_side_r <= s1_side_r;
    end
  end

  // stage 3: radicand
  logic            s3_v_r;
  rdft_pkg::sqrt_t s3_sq_r;
  rdft_pkg::side_t s3_side_r;

  assign s3_rdy = !s3_v_r || q4_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
    if (s3_rdy && s2_v_r) begin
      s3_sq_r.n    <= RAD_W'(s2_sqx_r) + RAD_W'(s2_sqy_r);
      s3_sq_r.rem  <= '0;
      s3_sq_r.root <= '0;
      s3_side_r    <= s2_side_r;
    end
  end

  // stages 4..6: square root, bit pairs from the top down
  rdft_sqrt_stage #(.STEPS(4), .FIRST_PAIR(rdft_pkg::PAIRS - 1)) u_sqrt_hi (
    .clk(clk), .rst_n(rst_n),
    .in_valid(s3_v_r), .in_ready(q4_rdy), .in_sq(s3_sq_r), .in_side(s3_side_r),
    .out_valid(q4_v), .out_ready(q5_rdy), .out_sq(q4_sq), .out_side(q4_side)
  );

  rdft_sqrt_stage #(.STEPS(4), .FIRST_PAIR(rdft_pkg::PAIRS - 5)) u_sqrt_mid (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q4_v), .in_ready(q5_rdy), .in_sq(q4_sq), .in_side(q4_side),
    .out_valid(q5_v), .out_ready(q6_rdy), .out_sq(q5_sq), .out_side(q5_side)
  );

  rdft_sqrt_stage #(.STEPS(rdft_pkg::PAIRS - 8), .FIRST_PAIR(rdft_pkg::PAIRS - 9)) u_sqrt_lo (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q5_v), .in_ready(q6_rdy), .in_sq(q5_sq), .in_side(q5_side),
    .out_valid(q6_v), .out_ready(o_rdy), .out_sq(q6_sq), .out_side(q6_side)
  );

  // stage 7: fade level and entry
  logic [9:0]                        step5;
  logic signed [SUM_W-1:0]           fade_sum, fade_q, lvl_raw;
  logic [rdft_pkg::LEVEL_W-1:0]      level;
  logic [rdft_pkg::TILE_W-1:0]       tile_num;
  logic [rdft_pkg::ENTRY_W-1:0]      entry_nxt;
  logic                              done_nxt;

  always_comb begin
    step5    = 10'(q6_side.step) * 10'(rdft_pkg::FADE_RATE);
    fade_sum = $signed(SUM_W'(q6_sq.root)) + SUM_W'(rdft_pkg::FADE_OFFSET)
             - $signed(SUM_W'(step5));
    // divide by four toward zero
    fade_q   = (fade_sum + (fade_sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0))) >>> 2;
    lvl_raw  = SUM_W'(rdft_pkg::LEVEL_MAX) - fade_q;
    if (lvl_raw[SUM_W-1]) begin
      level = '0;
    end else if (lvl_raw > SUM_W'(rdft_pkg::LEVEL_MAX)) begin
      level = rdft_pkg::LEVEL_W'(rdft_pkg::LEVEL_MAX);
    end else begin
      level = lvl_raw[rdft_pkg::LEVEL_W-1:0];
    end
    tile_num  = tile_base_r + rdft_pkg::TILE_W'(level);
    entry_nxt = {palette_sel_r, 2'b00, tile_num};
    done_nxt  = q6_side.step >= STEP_W'(rdft_pkg::DONE_STEP);
  end

  logic                         out_tvalid_r;
  logic [rdft_pkg::IDX_W-1:0]   out_idx_r;
  logic [rdft_pkg::ENTRY_W-1:0] out_entry_r;
  logic                         out_done_r;

  assign o_rdy = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (o_rdy) begin
      out_tvalid_r <= q6_v;
    end
    if (o_rdy && q6_v) begin
      out_idx_r   <= q6_side.idx;
      out_entry_r <= entry_nxt;
      out_done_r  <= done_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_done_r, out_entry_r, out_idx_r};

`ifndef SYNTH
  // a stalled distance stage keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_rdy |=> s1_v_r && $stable(s1_side_r) && $stable(s1_dx_r))
    else $error("stage 1 beat lost under stall");

  // the finished root is the floor square root of the radicand
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    q6_v |-> (32'(q6_sq.root) * 32'(q6_sq.root) <= 32'(q6_sq.n)) &&
             ((32'(q6_sq.root) + 32'd1) * (32'(q6_sq.root) + 32'd1) > 32'(q6_sq.n)))
    else $error("square root out of range");

  // flip bits of the entry stay clear
  a_flip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_entry_r[11:10] == 2'b00 && out_tdata[31:27] == 5'b0)
    else $error("entry flip bits set");
`endif

endmodule

// ----- hw/rtl/rdft_sqrt_stage.sv -----
// ---------------------------------------------------------------------------
// rdft_sqrt_stage
// One registered pipeline stage of the square root, STEPS digit steps deep.
// ---------------------------------------------------------------------------
module rdft_sqrt_stage #(
  parameter int STEPS      = 4,
  parameter int FIRST_PAIR = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rdft_pkg::sqrt_t     in_sq,
  input  rdft_pkg::side_t     in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output rdft_pkg::sqrt_t     out_sq,
  output rdft_pkg::side_t     out_side
);

  logic            v_r;
  rdft_pkg::sqrt_t sq_r;
  rdft_pkg::side_t side_r;
  rdft_pkg::sqrt_t sq_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    sq_nxt = in_sq;
    for (int k = 0; k < STEPS; k++) begin
      sq_nxt = rdft_pkg::sqrt_step(sq_nxt, in_sq.n[2*(FIRST_PAIR-k) +: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      sq_r   <= sq_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_sq    = sq_r;
  assign out_side  = side_r;

endmodule
